// ----- rtl/core/pdts_pkg.sv -----
`default_nettype none

package pdts_pkg;

    localparam int DAY_ENTRIES = 32;
    localparam int COUNT_BITS  = 20;

    localparam int SLOT_BITS = (DAY_ENTRIES > 1) ? $clog2(DAY_ENTRIES) : 1;
    localparam int USED_BITS = $clog2(DAY_ENTRIES + 1);

    localparam int INDEX_W    = 5;
    localparam int CNT_OUT_W  = 20;
    localparam int ADDR_BITS  = 3;
    localparam int DATA_BITS  = 32;
    localparam int INTERVAL_W = 16;

    // register index carried in paddr[2]
    localparam logic REG_SAMPLE_INTERVAL = 1'b0;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1;

    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_ONE  = 2'd1;
    localparam logic [1:0] LVL_TWO  = 2'd2;
    localparam logic [1:0] LVL_THREE = 2'd3;

    typedef struct packed {
        logic        [31:0] day_key;
        logic signed [15:0] temperature;
        logic        [1:0]  alert_level;
    } in_t;

    typedef struct packed {
        logic        [INDEX_W-1:0]   day_index;
        logic                        table_full;
        logic signed [15:0]          day_min;
        logic signed [15:0]          day_max;
        logic signed [47:0]          day_sum;
        logic        [CNT_OUT_W-1:0] day_count;
        logic        [CNT_OUT_W-1:0] level1_count;
        logic        [CNT_OUT_W-1:0] level2_count;
        logic        [CNT_OUT_W-1:0] level3_count;
        logic        [31:0]          alert_seconds;
    } out_t;

    // one table slot, as held in a cell
    typedef struct packed {
        logic        [31:0]           day;
        logic signed [15:0]           tmin;
        logic signed [15:0]           tmax;
        logic signed [47:0]           sum;
        logic        [COUNT_BITS-1:0] count;
        logic        [COUNT_BITS-1:0] lvl1;
        logic        [COUNT_BITS-1:0] lvl2;
        logic        [COUNT_BITS-1:0] lvl3;
        logic        [31:0]           alert_time;
    } entry_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pdts_cell.sv -----
`default_nettype none

module pdts_cell (
    input  wire logic            clk,
    input  wire logic            shift,
    input  wire pdts_pkg::entry_t d,
    output pdts_pkg::entry_t     q
);
    import pdts_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pdts_update.sv -----
`default_nettype none

module pdts_update (
    input  wire pdts_pkg::entry_t  head,
    input  wire logic              fresh,
    input  wire pdts_pkg::in_t     sample,
    input  wire logic [15:0]       interval,
    output pdts_pkg::entry_t       updated
);
    import pdts_pkg::*;

    entry_t             base;
    logic signed [48:0] sum_wide;
    logic        [32:0] alert_wide;

    always_comb
    begin
        if (fresh)
        begin
            base            = '0;
            base.day        = sample.day_key;
            base.tmin       = sample.temperature;
            base.tmax       = sample.temperature;
        end
        else
        begin
            base = head;
        end

        updated = base;

        if (sample.temperature < base.tmin)
        begin
            updated.tmin = sample.temperature;
        end
        if (sample.temperature > base.tmax)
        begin
            updated.tmax = sample.temperature;
        end

        sum_wide = {base.sum[47], base.sum} + 49'(sample.temperature);
        // sign of the 49-bit sum differs from bit 47 only on overflow
        if (sum_wide[48] != sum_wide[47])
        begin
            updated.sum = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            updated.sum = sum_wide[47:0];
        end

        updated.count = sat_inc(base.count);

        case (sample.alert_level)
            LVL_ONE:   updated.lvl1 = sat_inc(base.lvl1);
            LVL_TWO:   updated.lvl2 = sat_inc(base.lvl2);
            LVL_THREE: updated.lvl3 = sat_inc(base.lvl3);
            default:   updated.lvl1 = base.lvl1;
        endcase

        alert_wide = {1'b0, base.alert_time} + 33'(interval);
        if (sample.alert_level != LVL_NONE)
        begin
            updated.alert_time = alert_wide[32] ? 32'hFFFF_FFFF : alert_wide[31:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/per_day_temperature_stats_table_top.sv -----
// Per-day temperature statistics table.
// Input channel (in_valid / in_stall / in_data) carries one sample: day key,
// temperature in hundredths of a degree, alert level. Output channel
// (out_valid / out_stall / out_data) returns one result per sample: the
// day's slot with its updated min, max, sum, counts and alert seconds, or
// table_full set with all other fields zero when a new day found no slot.
// The table is a ring of DAY_ENTRIES cells that rotates one slot per clock
// while a sample is scanned, past a single update unit; a sample takes one
// full revolution, in the scan state, then moves to the finish state, which
// loads the result into the output register behind out_valid. No new sample
// is taken before the last one leaves the finish state, but one is taken
// while a finished result still waits in the output register.
// When the receiver stalls, the result holds in out_data; the next result
// waits in the block until the output register frees up.
// Reset clears the slot count (table empty), sets sample_interval_s to 1,
// and drops any sample in flight. sample_interval_s sits at APB address 0.
`default_nettype none

module per_day_temperature_stats_table_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire pdts_pkg::in_t                 in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output pdts_pkg::out_t                     out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pdts_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [pdts_pkg::DATA_BITS-1:0] pwdata,
    output logic [pdts_pkg::DATA_BITS-1:0]     prdata,
    output logic                               pready
);
    import pdts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [SLOT_BITS-1:0]   step_reg, step_next;
    logic [USED_BITS-1:0]   used_reg, used_next;
    logic                   found_reg, found_next;
    logic [INTERVAL_W-1:0]  interval_reg;
    in_t                    sample_reg;
    out_t                   res_reg;
    out_t                   out_data_reg;
    logic                   out_valid_reg;
    out_t                   full_res;

    entry_t                 ring [DAY_ENTRIES];
    entry_t                 head, updated, feed;
    logic                   scanning, last_step, hit, create, upd_en;
    logic                   in_xfer, out_load;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign scanning  = (state_reg == ST_SCAN);
    assign last_step = (step_reg == SLOT_BITS'(DAY_ENTRIES - 1));

    assign head   = ring[DAY_ENTRIES-1];
    assign hit    = scanning && !found_reg && (USED_BITS'(step_reg) < used_reg)
                    && (head.day == sample_reg.day_key);
    // every used slot has gone by without a match when the step reaches the count
    assign create = scanning && !found_reg && (USED_BITS'(step_reg) == used_reg);
    assign upd_en = hit || create;

    pdts_update u_update (
        .head     (head),
        .fresh    (create),
        .sample   (sample_reg),
        .interval (interval_reg),
        .updated  (updated)
    );

    assign feed = upd_en ? updated : head;

    for (genvar i = 0; i < DAY_ENTRIES; i++)
    begin : g_cell
        pdts_cell u_cell (
            .clk   (clk),
            .shift (scanning),
            .d     ((i == 0) ? feed : ring[(i == 0) ? 0 : i - 1]),
            .q     (ring[i])
        );
    end

    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // dropped sample: flag only
    always_comb
    begin
        full_res            = '0;
        full_res.table_full = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        used_next  = used_reg;
        found_next = found_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                    found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (upd_en)
                begin
                    found_next = 1'b1;
                end
                if (create)
                begin
                    used_next = used_reg + 1'b1;
                end
                if (last_step)
                begin
                    state_next = ST_FINISH;
                    step_next  = '0;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            used_reg      <= '0;
            found_reg     <= 1'b0;
            interval_reg  <= INTERVAL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            used_reg  <= used_next;
            found_reg <= found_next;
            if (psel && penable && pwrite && pready && (paddr[2] == REG_SAMPLE_INTERVAL))
            begin
                interval_reg <= pwdata[INTERVAL_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= in_data;
        end
        if (upd_en)
        begin
            res_reg.day_index     <= INDEX_W'(step_reg);
            res_reg.table_full    <= 1'b0;
            res_reg.day_min       <= updated.tmin;
            res_reg.day_max       <= updated.tmax;
            res_reg.day_sum       <= updated.sum;
            res_reg.day_count     <= CNT_OUT_W'(updated.count);
            res_reg.level1_count  <= CNT_OUT_W'(updated.lvl1);
            res_reg.level2_count  <= CNT_OUT_W'(updated.lvl2);
            res_reg.level3_count  <= CNT_OUT_W'(updated.lvl3);
            res_reg.alert_seconds <= updated.alert_time;
        end
        else if (scanning && last_step && !found_reg)
        begin
            res_reg <= full_res;
        end
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_SAMPLE_INTERVAL) ? DATA_BITS'(interval_reg) : '0;

    // slot count never passes the table size
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_BITS'(DAY_ENTRIES))
        else $error("slot count beyond table size");

    // a new result only comes out of the finish state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result without finished scan");

    // a dropped sample is reported only with every slot taken
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.table_full) |-> (used_reg == USED_BITS'(DAY_ENTRIES)))
        else $error("table_full with free slots");

    // at most one slot is claimed or updated per sample
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        (scanning && found_reg) |-> !upd_en)
        else $error("second update in one scan");

endmodule

`default_nettype wire

// ----- bench/per_day_temperature_stats_table_top_tb.sv -----
`timescale 1ns / 1ps

module per_day_temperature_stats_table_top_tb;

    import pdts_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int QUEUE_DEPTH  = 4;
    localparam int RAND_ITEMS   = 400;

    localparam logic [ADDR_BITS-1:0]  INTERVAL_ADDR = {REG_SAMPLE_INTERVAL, 2'b00};
    localparam logic [COUNT_BITS-1:0] COUNT_TOP     = '1;
    localparam longint                SUM_TOP       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint                SUM_BOTTOM    = -SUM_TOP - 1;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_t                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_t                 out_data;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_BITS-1:0] paddr     = '0;
    logic [DATA_BITS-1:0] pwdata    = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    per_day_temperature_stats_table_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // shadow of the day table
    logic [31:0]           day_tab   [DAY_ENTRIES];
    logic signed [15:0]    min_tab   [DAY_ENTRIES];
    logic signed [15:0]    max_tab   [DAY_ENTRIES];
    logic signed [47:0]    sum_tab   [DAY_ENTRIES];
    logic [COUNT_BITS-1:0] cnt_tab   [DAY_ENTRIES];
    logic [COUNT_BITS-1:0] l1_tab    [DAY_ENTRIES];
    logic [COUNT_BITS-1:0] l2_tab    [DAY_ENTRIES];
    logic [COUNT_BITS-1:0] l3_tab    [DAY_ENTRIES];
    logic [31:0]           alert_tab [DAY_ENTRIES];
    int                    used_slots = 0;
    logic [INTERVAL_W-1:0] interval   = INTERVAL_RESET;

    in_t  sample_queue[$];
    out_t expected_stats[$];

    int   queued_count   = 0;
    int   accepted_count = 0;
    int   errors         = 0;
    int   cycle_count    = 0;
    bit   sent_ok        = 1'b0;
    int   send_gap       = 0;
    int   stall_left     = 0;
    int   hold_left      = 0;
    int   hold_requests  = 0;
    int   holds_done     = 0;
    bit   quiet_sender   = 1'b0;
    bit   quiet_receiver = 1'b0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic out_t log_sample(in_t s);
        out_t        r;
        int          slot;
        int          i;
        longint      acc;
        logic [32:0] wide;
        r = '0;
        slot = -1;
        for (i = 0; i < used_slots; i++)
            if (slot < 0 && day_tab[i] == s.day_key)
                slot = i;
        if (slot < 0) begin
            if (used_slots >= DAY_ENTRIES) begin
                // dropped: only the flag is set
                r.table_full = 1'b1;
                return r;
            end
            slot = used_slots;
            used_slots++;
            day_tab[slot]   = s.day_key;
            min_tab[slot]   = s.temperature;
            max_tab[slot]   = s.temperature;
            sum_tab[slot]   = '0;
            cnt_tab[slot]   = '0;
            l1_tab[slot]    = '0;
            l2_tab[slot]    = '0;
            l3_tab[slot]    = '0;
            alert_tab[slot] = '0;
        end
        if (s.temperature < min_tab[slot])
            min_tab[slot] = s.temperature;
        if (s.temperature > max_tab[slot])
            max_tab[slot] = s.temperature;
        acc = longint'(sum_tab[slot]) + longint'(s.temperature);
        if (acc > SUM_TOP)
            acc = SUM_TOP;
        if (acc < SUM_BOTTOM)
            acc = SUM_BOTTOM;
        sum_tab[slot] = acc[47:0];
        if (cnt_tab[slot] != COUNT_TOP)
            cnt_tab[slot] = cnt_tab[slot] + 1'b1;
        case (s.alert_level)
            LVL_ONE:   if (l1_tab[slot] != COUNT_TOP) l1_tab[slot] = l1_tab[slot] + 1'b1;
            LVL_TWO:   if (l2_tab[slot] != COUNT_TOP) l2_tab[slot] = l2_tab[slot] + 1'b1;
            LVL_THREE: if (l3_tab[slot] != COUNT_TOP) l3_tab[slot] = l3_tab[slot] + 1'b1;
            default:   ;
        endcase
        if (s.alert_level != LVL_NONE) begin
            wide = {1'b0, alert_tab[slot]} + {17'h0, interval};
            alert_tab[slot] = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
        end
        r.day_index     = slot[INDEX_W-1:0];
        r.day_min       = min_tab[slot];
        r.day_max       = max_tab[slot];
        r.day_sum       = sum_tab[slot];
        r.day_count     = cnt_tab[slot];
        r.level1_count  = l1_tab[slot];
        r.level2_count  = l2_tab[slot];
        r.level3_count  = l3_tab[slot];
        r.alert_seconds = alert_tab[slot];
        return r;
    endfunction

    function automatic string show_stats(out_t r);
        return $sformatf("idx=%0d full=%0b min=%0d max=%0d sum=%0d cnt=%0d l=%0d/%0d/%0d al=%0d",
                         r.day_index, r.table_full, r.day_min, r.day_max, r.day_sum,
                         r.day_count, r.level1_count, r.level2_count, r.level3_count,
                         r.alert_seconds);
    endfunction

    task automatic flag_error(input string what);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, what);
    endtask

    task automatic check_result(input out_t exp, input out_t got);
        if (got.day_index !== exp.day_index || got.table_full !== exp.table_full ||
            got.day_min !== exp.day_min || got.day_max !== exp.day_max ||
            got.day_sum !== exp.day_sum || got.day_count !== exp.day_count ||
            got.level1_count !== exp.level1_count ||
            got.level2_count !== exp.level2_count ||
            got.level3_count !== exp.level3_count ||
            got.alert_seconds !== exp.alert_seconds)
            flag_error({"result mismatch\n  exp ", show_stats(exp), "\n  got ", show_stats(got)});
    endtask

    // mostly short idles, now and then a long one
    function automatic int draw_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    // mostly days already in the table, some fresh ones (new slot or table full)
    function automatic in_t random_sample();
        in_t s;
        int  r;
        r = $urandom_range(0, 99);
        if (used_slots > 0 && r < 80)
            s.day_key = day_tab[$urandom_range(0, used_slots - 1)];
        else
            s.day_key = $urandom;
        r = $urandom_range(0, 9);
        if (r == 0)
            s.temperature = 16'sh8000;
        else if (r == 1)
            s.temperature = 16'sh7FFF;
        else if (r < 5)
            s.temperature = 16'($urandom);
        else
            s.temperature = 16'($urandom_range(0, 4000) - 1000);
        s.alert_level = 2'($urandom_range(0, 3));
        return s;
    endfunction

    // input driver
    always @(negedge clk) begin
        if (rst_n && (!in_valid || sent_ok)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                in_data  <= sample_queue.pop_front();
                in_valid <= 1'b1;
                send_gap = quiet_sender ? 0 : draw_idle();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output stall
    always @(negedge clk) begin
        if (holds_done != hold_requests) begin
            hold_left = LONG_HOLD;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            stall_left = (quiet_receiver || $urandom_range(0, 3) != 0) ? 0 : draw_idle();
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // transfer monitor and scoreboard
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_stats.size() == 0)
                    flag_error({"unexpected result ", show_stats(out_data)});
                else
                    check_result(expected_stats.pop_front(), out_data);
            end
            if (in_valid && !in_stall) begin
                expected_stats.push_back(log_sample(in_data));
                accepted_count++;
            end
        end
        sent_ok <= rst_n && in_valid && !in_stall;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic feed(input in_t s);
        @(posedge clk);
        while (sample_queue.size() >= QUEUE_DEPTH)
            @(posedge clk);
        sample_queue.push_back(s);
        queued_count++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (accepted_count != queued_count || expected_stats.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_interval(input logic [INTERVAL_W-1:0] value);
        wait_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INTERVAL_ADDR;
        pwdata  <= {{(DATA_BITS-INTERVAL_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        interval = value;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        // read back in a second transfer
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[INTERVAL_W-1:0] !== interval)
            flag_error($sformatf("interval readback exp %0d got %0d",
                                 interval, prdata[INTERVAL_W-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input logic [INTERVAL_W-1:0] value, input bit burst,
                             input bit calm, input bit long_hold);
        in_t s;
        set_interval(value);
        @(posedge clk);
        quiet_sender   = burst;
        quiet_receiver = calm;
        if (long_hold)
            hold_requests++;
        repeat (RAND_ITEMS) begin
            @(negedge clk);
            s = random_sample();
            feed(s);
        end
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // interval still at its reset value; first sample of each day sets min and max
        feed(in_t'{32'h0000_0000, 16'sh0000, LVL_NONE});
        feed(in_t'{32'h0000_0000, 16'sh7FFF, LVL_ONE});
        feed(in_t'{32'h0000_0000, 16'sh8000, LVL_TWO});
        feed(in_t'{32'h0000_0000, 16'shFFFF, LVL_THREE});
        feed(in_t'{32'h0000_0000, 16'sh0000, LVL_NONE});
        feed(in_t'{32'hFFFF_FFFF, 16'sh8000, LVL_THREE});
        feed(in_t'{32'hFFFF_FFFF, 16'sh7FFF, LVL_NONE});
        feed(in_t'{32'h5555_AAAA, 16'sh5555, LVL_ONE});
        feed(in_t'{32'hAAAA_5555, 16'shAAAA, LVL_TWO});
        feed(in_t'{32'h5555_AAAA, 16'sh7FFF, LVL_THREE});

        set_interval(16'hFFFF);
        feed(in_t'{32'h0000_0000, 16'sh0001, LVL_ONE});
        feed(in_t'{32'h0000_0000, 16'sh0002, LVL_TWO});
        feed(in_t'{32'hFFFF_FFFF, 16'sh0003, LVL_THREE});
        feed(in_t'{32'hFFFF_FFFF, 16'sh8000, LVL_NONE});

        set_interval(16'h0000);
        feed(in_t'{32'h0000_0000, -16'sd5, LVL_THREE});
        feed(in_t'{32'hAAAA_5555, 16'sd10, LVL_ONE});
        feed(in_t'{32'hAAAA_5555, 16'sh7FFF, LVL_NONE});

        run_phase(INTERVAL_W'($urandom_range(2, 65534)), 1'b0, 1'b0, 1'b0);
        // receiver holds off long while the sender keeps pushing
        run_phase(16'hFFFF, 1'b1, 1'b0, 1'b1);
        run_phase(16'h0000, 1'b0, 1'b1, 1'b0);
        run_phase(16'h0001, 1'b0, 1'b0, 1'b0);
        run_phase(INTERVAL_W'($urandom_range(2, 65534)), 1'b1, 1'b1, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_stats.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_stats.size()));
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pdts_pkg.sv
rtl/core/pdts_cell.sv
rtl/core/pdts_update.sv
rtl/core/per_day_temperature_stats_table_top.sv
bench/per_day_temperature_stats_table_top_tb.sv
